### hdl/acis_pkg.sv
// acis_pkg: types and constants of the alternating chamber inflation sequencer.
// Word structs, phase codes, register indexes and pressure scaling.
// No dependencies.
package acis_pkg;

    localparam int unsigned TICKS_PER_SECOND = 500;
    localparam int unsigned HOLD_W           = 17;
    localparam int unsigned SCALE_MUL        = 887;
    localparam int unsigned SCALE_SHIFT      = 16;
    localparam int unsigned RAW_W            = 12;
    localparam int unsigned PROD_W           = 22;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 8;
    localparam int unsigned LOAD_PROD_W      = 25;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PRESSURE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSOR_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_INFLATE = 2'd1,
        PH_HOLD    = 2'd2
    } t_phase;

    typedef struct packed {
        logic              enable;
        logic [RAW_W-1:0]  sensor_one_raw;
        logic [RAW_W-1:0]  sensor_two_raw;
    } t_in_word;

    typedef struct packed {
        logic       led_on;
        logic [7:0] compressor_drive;
        logic       valve_one_drive;
        logic       valve_two_drive;
        logic       chamber_select;
        logic [1:0] phase;
    } t_out_word;

    typedef struct packed {
        t_phase            phase;
        logic              active_chamber;
        logic [HOLD_W-1:0] hold_counter;
    } t_state;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] target_pressure;
        logic [CFG_DATA_W-1:0] compressor_level;
        logic [HOLD_W-1:0]     hold_load;
    } t_cfg;

    // Hold tick count for a seconds setting, saturated to the counter width.
    function automatic logic [HOLD_W-1:0] hold_load_of(input logic [CFG_DATA_W-1:0] secs);
        logic [LOAD_PROD_W-1:0] prod;
        prod = LOAD_PROD_W'(secs) * LOAD_PROD_W'(TICKS_PER_SECOND);
        hold_load_of = (prod > LOAD_PROD_W'(HOLD_MAX)) ? HOLD_MAX : prod[HOLD_W-1:0];
    endfunction

endpackage

### hdl/acis_step.sv
// acis_step: next state and result word for one sample tick.
// Combinational; depends on acis_pkg.
module acis_step (
    input  acis_pkg::t_state    i_state,
    input  acis_pkg::t_in_word  i_word,
    input  acis_pkg::t_cfg      i_cfg,
    output acis_pkg::t_state    o_state,
    output acis_pkg::t_out_word o_word
);

    logic                             raw_sel;
    logic [acis_pkg::RAW_W-1:0]       raw;
    logic [acis_pkg::PROD_W-1:0]      prod;
    logic [acis_pkg::CFG_DATA_W-1:0]  pressure;
    logic                             evaluate;
    logic [acis_pkg::CFG_DATA_W-1:0]  comp;
    acis_pkg::t_state                 nxt;
    logic                             run;

    always_comb begin
        nxt      = i_state;
        evaluate = 1'b1;
        comp     = '0;

        case (i_state.phase)
            acis_pkg::PH_HOLD: begin
                if (i_state.hold_counter != '0) begin
                    nxt.hold_counter = i_state.hold_counter - acis_pkg::HOLD_W'(1);
                    evaluate         = 1'b0;
                end else begin
                    nxt.active_chamber = ~i_state.active_chamber;
                    nxt.phase          = acis_pkg::PH_IDLE;
                end
            end
            acis_pkg::PH_INFLATE: nxt.phase = acis_pkg::PH_INFLATE;
            default: nxt.phase = acis_pkg::PH_IDLE;
        endcase

        raw_sel  = nxt.active_chamber;
        raw      = raw_sel ? i_word.sensor_two_raw : i_word.sensor_one_raw;
        prod     = acis_pkg::PROD_W'(raw) * acis_pkg::PROD_W'(acis_pkg::SCALE_MUL);
        pressure = acis_pkg::CFG_DATA_W'(prod[acis_pkg::PROD_W-1:acis_pkg::SCALE_SHIFT]);

        if (evaluate) begin
            if (!i_word.enable && nxt.phase == acis_pkg::PH_IDLE) begin
                nxt.active_chamber = 1'b0;
            end else if (pressure > i_cfg.target_pressure || !i_word.enable) begin
                nxt.phase        = acis_pkg::PH_HOLD;
                nxt.hold_counter = i_cfg.hold_load;
            end else begin
                nxt.phase = acis_pkg::PH_INFLATE;
                comp      = i_cfg.compressor_level;
            end
        end

        run                     = nxt.phase != acis_pkg::PH_IDLE;
        o_state                 = nxt;
        o_word.led_on           = run;
        o_word.compressor_drive = comp;
        o_word.valve_one_drive  = run && !nxt.active_chamber;
        o_word.valve_two_drive  = run && nxt.active_chamber;
        o_word.chamber_select   = nxt.active_chamber;
        o_word.phase            = nxt.phase;
    end

endmodule

### hdl/alternating_chamber_inflation_sequencer_unit.sv
// Alternating chamber inflation sequencer, top level.
// Config registers, sequencer state and result register; uses acis_pkg, acis_step.
//
//   channel   signals                                   word
//   in        i_in_valid / o_in_ready / i_in_word        t_in_word (enable, two raw readings)
//   out       o_out_valid / i_out_ready / o_out_word     t_out_word (drives, select, phase)
//   config    i_cfg_we / i_cfg_idx / i_cfg_data          8-bit registers 0..2, write only
//
// One word per cycle while the output is drained: an accepted tick updates the state and
// loads the result register on the same edge; the result shows in the following cycle.
// A new word is taken while the result register is empty or being drained.
// Synchronous active-low reset clears state, config registers and the output valid.
// Hold tick count is computed when hold_seconds is written.
module alternating_chamber_inflation_sequencer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  acis_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output acis_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_we,
    input  logic [acis_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [acis_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    acis_pkg::t_cfg      r_cfg;
    acis_pkg::t_state    r_state;
    acis_pkg::t_state    n_state;
    acis_pkg::t_out_word r_out_word;
    acis_pkg::t_out_word n_out_word;
    logic                r_out_valid;
    logic                accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    acis_step u_step (
        .i_state (r_state),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acis_pkg::CFG_TARGET_PRESSURE:  r_cfg.target_pressure  <= i_cfg_data;
                acis_pkg::CFG_COMPRESSOR_LEVEL: r_cfg.compressor_level <= i_cfg_data;
                acis_pkg::CFG_HOLD_SECONDS:     r_cfg.hold_load <= acis_pkg::hold_load_of(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= acis_pkg::PH_IDLE;
            r_state.active_chamber <= 1'b0;
            r_state.hold_counter   <= '0;
            r_out_valid            <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
